[sv/rfd_pkg.sv]
// Shared types, constants and helpers for the RFID ASCII frame decoder.
// Used by the interfaces, the controller, the datapath and the top level.
package rfd_pkg;

   localparam int CHAR_W  = 8;
   localparam int NIB_W   = 4;
   localparam int POS_W   = 4;
   localparam int TAG_W   = 32;
   localparam int DIGIT_W = 6;

   localparam int MAX_DIGITS = 10;
   localparam int BCD_W      = MAX_DIGITS * NIB_W;
   localparam int STEP_W     = $clog2(TAG_W);
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

   localparam logic [POS_W-1:0] FIRST_POS     = 4'd1;
   localparam logic [POS_W-1:0] TAG_FIRST_POS = 4'd3;
   localparam logic [POS_W-1:0] DATA_LAST_POS = 4'd10;
   localparam logic [POS_W-1:0] CHECK_LO_POS  = 4'd12;
   localparam logic [POS_W-1:0] IDLE_POS      = 4'd13;

   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0]  ASCII_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0]  ASCII_UPPER_F = 8'h46;
   localparam logic [DIGIT_W-1:0] DIGIT_ZERO  = 6'h30;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_TRIM,
      ST_EMIT
   } rfd_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic conv_step;
      logic trim_step;
      logic emit_step;
   } rfd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_end;
      logic conv_last;
      logic lead_zero;
      logic last_left;
      logic out_free;
   } rfd_sts_type;

   // Upper-case hex character to nibble; anything else reads as zero.
   function automatic logic [NIB_W-1:0] rfd_nibble(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] diff;
      diff = '0;
      if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
         diff = c - ASCII_ZERO;
      end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_F) begin
         diff = c - ASCII_UPPER_A + 8'd10;
      end
      return diff[NIB_W-1:0];
   endfunction

endpackage

[sv/rfd_if.sv]
// Valid/ready channel interfaces for the frame decoder.
// Depends on rfd_pkg for the field widths.
interface rfd_req_if;
   import rfd_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] ch;
   logic              frame_start;

   modport source (output valid, output ch, output frame_start, input ready);
   modport sink   (input valid, input ch, input frame_start, output ready);
endinterface

interface rfd_rsp_if;
   import rfd_pkg::*;
   logic               valid;
   logic               ready;
   logic [DIGIT_W-1:0] digit_char;
   logic               checksum_ok;
   logic [TAG_W-1:0]   tag_value;
   logic               last_digit;

   modport source (output valid, output digit_char, output checksum_ok,
                   output tag_value, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input checksum_ok,
                   input tag_value, input last_digit, output ready);
endinterface

[sv/rfd_ctrl.sv]
// Controller of the frame decoder: sequences character intake, the binary
// to BCD conversion, leading-zero removal and digit output. Uses rfd_pkg.
module rfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rfd_pkg::rfd_sts_type sts,
   output rfd_pkg::rfd_cmd_type cmd
);
   import rfd_pkg::*;

   rfd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && sts.frame_end) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (sts.conv_last) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            if (sts.lead_zero) begin
               cmd.trim_step = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_step = 1'b1;
               if (sts.last_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/rfd_dpath.sv]
// Datapath of the frame decoder: frame position, hex pairing, checksum and
// tag accumulation, shift-add-3 BCD conversion and the output register.
// Uses rfd_pkg; driven by commands from rfd_ctrl.
module rfd_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  rfd_pkg::rfd_cmd_type          cmd,
   output rfd_pkg::rfd_sts_type          sts,
   input  logic [rfd_pkg::CHAR_W-1:0]    req_ch,
   input  logic                          req_frame_start,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [rfd_pkg::DIGIT_W-1:0]   rsp_digit_char,
   output logic                          rsp_checksum_ok,
   output logic [rfd_pkg::TAG_W-1:0]     rsp_tag_value,
   output logic                          rsp_last_digit
);
   import rfd_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [NIB_W-1:0]   hi_ff, hi_in;
   logic [CHAR_W-1:0]  xor_ff, xor_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic               ok_ff, ok_in;
   logic [TAG_W-1:0]   conv_ff, conv_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic               out_valid_ff, out_valid_in;
   logic [DIGIT_W-1:0] out_digit_ff, out_digit_in;
   logic               out_ok_ff, out_ok_in;
   logic [TAG_W-1:0]   out_tag_ff, out_tag_in;
   logic               out_last_ff, out_last_in;

   logic [NIB_W-1:0]   nib;
   logic [CHAR_W-1:0]  byte_val;
   logic               in_frame;
   logic [BCD_W-1:0]   bcd_adj;
   logic [NIB_W-1:0]   top_digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= IDLE_POS;
         hi_ff        <= '0;
         xor_ff       <= '0;
         tag_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         hi_ff        <= hi_in;
         xor_ff       <= xor_in;
         tag_ff       <= tag_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff        <= ok_in;
      conv_ff      <= conv_in;
      bcd_ff       <= bcd_in;
      step_ff      <= step_in;
      cnt_ff       <= cnt_in;
      out_digit_ff <= out_digit_in;
      out_ok_ff    <= out_ok_in;
      out_tag_ff   <= out_tag_in;
      out_last_ff  <= out_last_in;
   end

   // Each BCD digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         bcd_adj[i*NIB_W +: NIB_W] = (bcd_ff[i*NIB_W +: NIB_W] >= 4'd5)
                                     ? bcd_ff[i*NIB_W +: NIB_W] + 4'd3
                                     : bcd_ff[i*NIB_W +: NIB_W];
      end
   end

   assign nib       = rfd_nibble(req_ch);
   assign byte_val  = {hi_ff, nib};
   assign in_frame  = (pos_ff >= FIRST_POS) && (pos_ff <= CHECK_LO_POS);
   assign top_digit = bcd_ff[BCD_W-1 -: NIB_W];

   always_comb begin
      pos_in       = pos_ff;
      hi_in        = hi_ff;
      xor_in       = xor_ff;
      tag_in       = tag_ff;
      ok_in        = ok_ff;
      conv_in      = conv_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_digit_in = out_digit_ff;
      out_ok_in    = out_ok_ff;
      out_tag_in   = out_tag_ff;
      out_last_in  = out_last_ff;

      if (cmd.take) begin
         if (req_frame_start) begin
            pos_in = FIRST_POS;
            hi_in  = '0;
            xor_in = '0;
            tag_in = '0;
         end else if (in_frame) begin
            pos_in = pos_ff + 4'd1;
            if (pos_ff[0]) begin
               hi_in = nib;
            end else if (pos_ff <= DATA_LAST_POS) begin
               xor_in = xor_ff ^ byte_val;
               if (pos_ff > TAG_FIRST_POS) begin
                  tag_in = {tag_ff[TAG_W-CHAR_W-1:0], byte_val};
               end
            end else begin
               // Checksum pair complete: close the frame and start conversion.
               pos_in  = IDLE_POS;
               ok_in   = (xor_ff == byte_val);
               conv_in = tag_ff;
               bcd_in  = '0;
               step_in = '0;
               cnt_in  = CNT_W'(MAX_DIGITS);
            end
         end
      end

      if (cmd.conv_step) begin
         bcd_in  = {bcd_adj[BCD_W-2:0], conv_ff[TAG_W-1]};
         conv_in = {conv_ff[TAG_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
      end

      if (cmd.trim_step) begin
         bcd_in = {bcd_ff[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
         cnt_in = cnt_ff - 1'b1;
      end

      if (cmd.emit_step) begin
         bcd_in       = {bcd_ff[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
         cnt_in       = cnt_ff - 1'b1;
         out_valid_in = 1'b1;
         out_digit_in = DIGIT_ZERO | {{(DIGIT_W-NIB_W){1'b0}}, top_digit};
         out_ok_in    = ok_ff;
         out_tag_in   = tag_ff;
         out_last_in  = (cnt_ff == CNT_W'(1));
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign sts.frame_end = !req_frame_start && (pos_ff == CHECK_LO_POS);
   assign sts.conv_last = (step_ff == STEP_W'(TAG_W - 1));
   assign sts.lead_zero = (top_digit == '0) && (cnt_ff != CNT_W'(1));
   assign sts.last_left = (cnt_ff == CNT_W'(1));
   assign sts.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid       = out_valid_ff;
   assign rsp_digit_char  = out_digit_ff;
   assign rsp_checksum_ok = out_ok_ff;
   assign rsp_tag_value   = out_tag_ff;
   assign rsp_last_digit  = out_last_ff;

endmodule

[sv/rfid_ascii_frame_decoder_unit.sv]
// Top level of the RFID ASCII frame decoder: controller, datapath and the
// two channel interfaces. Depends on rfd_pkg, rfd_if, rfd_ctrl, rfd_dpath.
//
// The block takes one frame character per cycle while no earlier frame is
// being converted or output: a start character, ten data hex characters and
// two checksum hex characters. The character that completes the checksum
// starts a shift-add-3 binary to decimal conversion of the 32-bit tag, one
// bit a cycle. Leading zeros are then dropped at one digit a cycle, and the
// digits leave through an output register at one per cycle while the sink
// takes them. Dropped zeros and emitted digits always add up to ten digits.
// New characters are refused from the frame's last character until the
// final digit sits in the output register.
module rfid_ascii_frame_decoder_unit (
   input  logic      clock,
   input  logic      reset,
   rfd_req_if.sink   req_chan,
   rfd_rsp_if.source rsp_chan
);
   import rfd_pkg::*;

   rfd_cmd_type cmd;
   rfd_sts_type sts;

   rfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rfd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_ch          (req_chan.ch),
      .req_frame_start (req_chan.frame_start),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_digit_char  (rsp_chan.digit_char),
      .rsp_checksum_ok (rsp_chan.checksum_ok),
      .rsp_tag_value   (rsp_chan.tag_value),
      .rsp_last_digit  (rsp_chan.last_digit)
   );

   // Every emitted character is a decimal digit.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.digit_char >= DIGIT_ZERO) &&
                         (rsp_chan.digit_char <= DIGIT_ZERO + 6'd9))
      else $error("digit outside 0..9");

   // While a run of digits is still going, no character is taken.
   a_no_intake_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_digit
      |-> !req_chan.ready)
      else $error("character taken in the middle of a digit run");

   // The frame's closing character moves the controller into conversion and stops further intake.
   a_frame_end_blocks: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && sts.frame_end
      |=> !req_chan.ready && cmd.conv_step)
      else $error("conversion did not follow a completed frame");

   // A waiting digit stays in place until the sink takes it.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready
      |=> rsp_chan.valid && $stable(rsp_chan.digit_char) &&
          $stable(rsp_chan.last_digit))
      else $error("waiting digit changed before its transfer");

endmodule
